// File: sv/fsbi_pkg.sv
// Package for the flow-shop best-insertion engine.
// Holds port widths, operation and status codes, controller states and saturating add.
// No dependencies.
package fsbi_pkg;

  localparam int OP_W   = 3;
  localparam int JOB_W  = 9;
  localparam int MACH_W = 5;
  localparam int TIME_W = 10;
  localparam int STAT_W = 2;
  localparam int VAL_W  = 20;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 6;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_APPEND  = 3'd2,
    OP_EVAL    = 3'd3,
    OP_EVAL_IN = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_RD, S_EX, S_POST, S_SH_RD, S_SH_WR, S_PLACE, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PS_HEAD, PS_INS, PS_TAIL
  } pass_e;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W:0] s);
    sat_add = s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

endpackage

// File: sv/fsbi_in_if.sv
// Input channel of the flow-shop best-insertion engine.
// Depends on fsbi_pkg for field widths.
interface fsbi_in_if import fsbi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [JOB_W-1:0]  job;
  logic [MACH_W-1:0] machine;
  logic [TIME_W-1:0] proc_time;
  modport source (output valid, op, job, machine, proc_time, input ready);
  modport sink   (input valid, op, job, machine, proc_time, output ready);
endinterface

// File: sv/fsbi_out_if.sv
// Result channel of the flow-shop best-insertion engine.
// Depends on fsbi_pkg for field widths.
interface fsbi_out_if import fsbi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  best_makespan;
  logic [POS_W-1:0]  best_position;
  logic [POS_W-1:0]  seq_length;
  modport source (output valid, status, best_makespan, best_position, seq_length,
                  input ready);
  modport sink   (input valid, status, best_makespan, best_position, seq_length,
                  output ready);
endinterface

// File: sv/flow_shop_best_insertion_top.sv
// Writes, clears and appends go straight to the result register; an evaluation of a job against
// n jobs on m machines walks every row through a read-then-write step on the head, tail and
// time memories; an insertion then shifts the later jobs up one place and places the new job.
// One word is in work at a time; the result register frees the input once loaded.
// Reset clears the controller, the job count and the machine count (to 1); memories
// are not cleared.
module flow_shop_best_insertion_top import fsbi_pkg::*; #(
  parameter int MAX_JOBS     = 512,
  parameter int MAX_MACHINES = 32,
  parameter int TIME_BITS    = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  fsbi_in_if.sink          in_i,
  fsbi_out_if.source       out_o
);

  localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int JW  = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int PAW = $clog2(MAX_JOBS * MAX_MACHINES);
  localparam int HAW = $clog2((MAX_JOBS + 1) * MAX_MACHINES);

  logic [TIME_BITS-1:0] pt_mem [MAX_JOBS*MAX_MACHINES];
  logic [JW-1:0]        sq_mem [MAX_JOBS];
  logic [VAL_W-1:0]     hd_mem [(MAX_JOBS+1)*MAX_MACHINES];
  logic [VAL_W-1:0]     tl_mem [(MAX_JOBS+1)*MAX_MACHINES];

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;
  logic [CFG_W-1:0] cfg_q;
  logic [CW-1:0] count_q, count_d, n_q, n_d, row_q, row_d, pos_q, pos_d, ptr_q, ptr_d;
  logic [MW:0]   m_q, m_d;
  logic [MW-1:0] c_q, c_d;
  logic [JW-1:0] nj_q, nj_d;
  logic          ins_q, ins_d;
  logic [VAL_W-1:0] cur_q, cur_d, mk_q, mk_d, best_q, best_d;
  logic [STAT_W-1:0] rstat_q, rstat_d;
  logic out_valid_q, out_valid_d, out_load;
  logic [STAT_W-1:0] out_stat_q;
  logic [VAL_W-1:0]  out_mk_q;
  logic [POS_W-1:0]  out_pos_q, out_len_q;

  logic [TIME_BITS-1:0] pt_rd_q;
  logic [JW-1:0]        sq_rd_q;
  logic [VAL_W-1:0]     hd_rd_q, tl_rd_q;
  logic [PAW-1:0] pt_ra, pt_wa;
  logic [HAW-1:0] hd_ra, tl_ra, hd_wa, tl_wa;
  logic [JW-1:0]  sq_ra, sq_wa, sq_wd, job_j, sel_j;
  logic pt_we, sq_we, sq_re, hd_we, tl_we;
  logic [VAL_W-1:0] a_val, mx, new_val, v_val, hd_wd;
  logic accept, bad_job, bad_mach, last_c;
  logic [31:0] m_eff;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign job_j    = JW'(in_i.job);
  assign bad_job  = 32'(in_i.job) >= MAX_JOBS;
  assign bad_mach = 32'(in_i.machine) >= MAX_MACHINES;
  assign m_eff    = (cfg_q == '0) ? 32'd1 :
                    (32'(cfg_q) > MAX_MACHINES) ? 32'(MAX_MACHINES) : 32'(cfg_q);
  assign last_c   = (pass_q == PS_TAIL) ? (c_q == '0) : ((MW+1)'(c_q) == m_q - 1'b1);
  assign sel_j    = (pass_q == PS_INS) ? nj_q : sq_rd_q;

  // Element step of the current pass.
  always_comb begin
    a_val = '0;
    v_val = '0;
    if (pass_q == PS_HEAD) begin
      a_val = (row_q == CW'(1)) ? '0 : hd_rd_q;
    end else if (pass_q == PS_INS) begin
      a_val = (row_q == '0) ? '0 : hd_rd_q;
    end else begin
      a_val = (row_q + 1'b1 == n_q) ? '0 : tl_rd_q;
    end
    mx      = (a_val > cur_q) ? a_val : cur_q;
    new_val = sat_add({1'b0, mx} + (VAL_W+1)'(pt_rd_q));
    hd_wd   = new_val;
    if (pass_q == PS_TAIL) begin
      v_val = (row_q == n_q) ? hd_rd_q : sat_add({1'b0, hd_rd_q} + {1'b0, new_val});
    end
  end

  // Memory addresses.
  always_comb begin
    hd_ra = HAW'(row_q) * HAW'(MAX_MACHINES) + HAW'(c_q);
    if (pass_q == PS_HEAD) hd_ra = HAW'(row_q - 1'b1) * HAW'(MAX_MACHINES) + HAW'(c_q);
    tl_ra = HAW'(row_q + 1'b1) * HAW'(MAX_MACHINES) + HAW'(c_q);
    pt_ra = PAW'(sel_j) * PAW'(MAX_MACHINES) + PAW'(c_q);
    hd_wa = HAW'(row_q) * HAW'(MAX_MACHINES) + HAW'(c_q);
    tl_wa = hd_wa;
    pt_wa = PAW'(job_j) * PAW'(MAX_MACHINES) + PAW'(in_i.machine);
    hd_we = (state_q == S_EX) && (pass_q != PS_TAIL);
    tl_we = (state_q == S_EX) && (pass_q == PS_TAIL) && (row_q != n_q);
    pt_we = accept && (op_e'(in_i.op) == OP_WRITE) && !bad_job && !bad_mach;
    sq_re = ((state_q == S_ROW) && (pass_q != PS_INS) && (row_q != n_q || pass_q == PS_HEAD))
            || (state_q == S_SH_RD);
    sq_ra = (state_q == S_SH_RD) ? JW'(ptr_q - 1'b1) :
            (pass_q == PS_HEAD) ? JW'(row_q - 1'b1) : JW'(row_q);
    sq_we = 1'b0;
    sq_wa = JW'(count_q);
    sq_wd = job_j;
    if (accept && op_e'(in_i.op) == OP_APPEND && !bad_job && 32'(count_q) < MAX_JOBS) begin
      sq_we = 1'b1;
    end else if (state_q == S_SH_WR) begin
      sq_we = 1'b1;
      sq_wa = JW'(ptr_q);
      sq_wd = sq_rd_q;
    end else if (state_q == S_PLACE) begin
      sq_we = 1'b1;
      sq_wa = JW'(pos_q);
      sq_wd = nj_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_wa] <= TIME_BITS'(in_i.proc_time);
    if (sq_we) sq_mem[sq_wa] <= sq_wd;
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    if (tl_we) tl_mem[tl_wa] <= new_val;
    if (sq_re) sq_rd_q <= sq_mem[sq_ra];
    pt_rd_q <= pt_mem[pt_ra];
    hd_rd_q <= hd_mem[hd_ra];
    tl_rd_q <= tl_mem[tl_ra];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((op_e'(in_i.op) == OP_EVAL || op_e'(in_i.op) == OP_EVAL_IN) && !bad_job) begin
            state_d = S_ROW;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_ROW: state_d = S_RD;
      S_RD:  state_d = S_EX;
      S_EX: begin
        if (!last_c) state_d = S_RD;
        else if (pass_q == PS_TAIL && row_q == '0) state_d = S_POST;
        else state_d = S_ROW;
      end
      S_POST: begin
        if (!ins_q) state_d = S_OUT;
        else if (n_q > pos_q) state_d = S_SH_RD;
        else state_d = S_PLACE;
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = (ptr_q - 1'b1 > pos_q) ? S_SH_RD : S_PLACE;
      S_PLACE: state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    pass_d = pass_q;  count_d = count_q; n_d = n_q; row_d = row_q; pos_d = pos_q;
    ptr_d = ptr_q;    m_d = m_q;         c_d = c_q; nj_d = nj_q;   ins_d = ins_q;
    cur_d = cur_q;    mk_d = mk_q;       best_d = best_q;          rstat_d = rstat_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rstat_d = ST_OK;
          best_d  = '0;
          pos_d   = '0;
          nj_d    = job_j;
          n_d     = count_q;
          m_d     = (MW+1)'(m_eff);
          ins_d   = 1'b0;
          case (op_e'(in_i.op))
            OP_WRITE:  if (bad_job || bad_mach) rstat_d = ST_BAD;
            OP_CLEAR:  count_d = '0;
            OP_APPEND: begin
              if (bad_job) rstat_d = ST_BAD;
              else if (32'(count_q) >= MAX_JOBS) rstat_d = ST_FULL;
              else count_d = count_q + 1'b1;
            end
            OP_EVAL, OP_EVAL_IN: begin
              if (bad_job) begin
                rstat_d = ST_BAD;
              end else begin
                pass_d = (count_q == '0) ? PS_INS : PS_HEAD;
                row_d  = (count_q == '0) ? '0 : CW'(1);
                if (op_e'(in_i.op) == OP_EVAL_IN) begin
                  if (32'(count_q) >= MAX_JOBS) rstat_d = ST_FULL;
                  else ins_d = 1'b1;
                end
              end
            end
            default: rstat_d = ST_BAD;
          endcase
        end
      end
      S_ROW: begin
        cur_d = '0;
        mk_d  = '0;
        c_d   = (pass_q == PS_TAIL) ? MW'(m_q - 1'b1) : '0;
      end
      S_EX: begin
        cur_d = new_val;
        if (v_val > mk_q) mk_d = v_val;
        if (!last_c) begin
          c_d = (pass_q == PS_TAIL) ? c_q - 1'b1 : c_q + 1'b1;
        end else begin
          unique case (pass_q)
            PS_HEAD: begin
              if (row_q == n_q) begin
                pass_d = PS_INS;
                row_d  = '0;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
            PS_INS: begin
              if (row_q == n_q) pass_d = PS_TAIL;
              else row_d = row_q + 1'b1;
            end
            default: begin
              if (row_q == n_q || ((v_val > mk_q) ? v_val : mk_q) <= best_q) begin
                best_d = (v_val > mk_q) ? v_val : mk_q;
                pos_d  = row_q;
              end
              row_d = row_q - 1'b1;
            end
          endcase
        end
      end
      S_POST:  ptr_d = n_q;
      S_SH_WR: ptr_d = ptr_q - 1'b1;
      S_PLACE: count_d = count_q + 1'b1;
      S_OUT:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PS_HEAD;
      count_q     <= '0;
      cfg_q       <= CFG_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  row_q <= row_d;  pos_q <= pos_d;  ptr_q <= ptr_d;  m_q <= m_d;
    c_q <= c_d;  nj_q <= nj_d;    ins_q <= ins_d;  cur_q <= cur_d;  mk_q <= mk_d;
    best_q <= best_d;  rstat_q <= rstat_d;
    if (out_load) begin
      out_stat_q <= rstat_q;
      out_mk_q   <= best_q;
      out_pos_q  <= POS_W'(pos_q);
      out_len_q  <= POS_W'(count_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_stat_q;
  assign out_o.best_makespan = out_mk_q;
  assign out_o.best_position = out_pos_q;
  assign out_o.seq_length    = out_len_q;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_JOBS) else $error("job count above capacity");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("idle right after accepting a word");
  a_machine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EX |-> (MW+1)'(c_q) < m_q) else $error("machine counter out of range");
`endif

endmodule
